@@ hw/rtl/bad_pkg.sv @@
// Package for the box align and distribute block: constants, types and helpers.
`default_nettype none
package bad_pkg;

  localparam int MAX_NODES = 32;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int ACC_W     = CNT_W + 38;
  localparam int DCNT_W    = $clog2(ACC_W + 1);

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_FB_W = 2'd1;
  localparam logic [1:0] REG_FB_H = 2'd2;

  typedef enum logic [2:0] {
    MODE_LEFT, MODE_HCENTER, MODE_RIGHT, MODE_TOP,
    MODE_VCENTER, MODE_BOTTOM, MODE_DIST_H, MODE_DIST_V
  } mode_t;

  typedef enum logic [1:0] {ST_OK, ST_FEW, ST_SIZE, ST_SAT} status_t;

  typedef enum logic [1:0] {CELL_HOLD, CELL_INSERT, CELL_ROTATE, CELL_SHIFT} cell_op_t;

  typedef enum logic [2:0] {S_LOAD, S_DECIDE, S_DIV, S_CALC, S_EMIT, S_PICK} state_t;

  typedef struct packed {
    cell_op_t op;
    logic     by_y;
    logic     sorted;
  } cell_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   seq;
    logic [31:0]        id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
  } entry_t;

  typedef struct packed {
    logic [31:0]        box_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic               size_is_override;
    logic               last_box;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        out_id;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [1:0]         status;
    logic               last_result;
  } out_word_t;

  function automatic logic out_of_range(input logic signed [ACC_W-1:0] v);
    return (v > ACC_W'(64'sd2147483647)) || (v < ACC_W'(-64'sd2147483648));
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(64'sd2147483647)) r = 32'sh7FFFFFFF;
    else if (v < ACC_W'(-64'sd2147483648)) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bad_cell.sv @@
// One storage cell of the box chain: holds a box, inserts in order, shifts.
`default_nettype none
module bad_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bad_pkg::cell_ctl_t ctl,
  input  wire bad_pkg::entry_t new_entry,
  input  wire bad_pkg::entry_t left_entry,
  input  wire logic            left_before,
  input  wire bad_pkg::entry_t right_entry,
  output bad_pkg::entry_t      entry,
  output logic                 goes_first
);
  import bad_pkg::*;

  entry_t             entry_r, entry_nxt;
  logic signed [31:0] key_new, key_own;

  always_comb begin
    key_new = ctl.by_y ? new_entry.y : new_entry.x;
    key_own = ctl.by_y ? entry_r.y : entry_r.x;
    goes_first = !entry_r.valid ||
                 (ctl.sorted && ((key_new < key_own) ||
                                 ((key_new == key_own) && (new_entry.id < entry_r.id))));
  end

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.op)
      CELL_HOLD: entry_nxt = entry_r;
      CELL_INSERT: begin
        if (left_before) entry_nxt = left_entry;
        else if (goes_first) entry_nxt = new_entry;
      end
      CELL_ROTATE,
      CELL_SHIFT: entry_nxt = right_entry;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
endmodule
`default_nettype wire

@@ hw/rtl/box_align_distribute.sv @@
// Top level: loads a set of boxes into a cell chain, then aligns or distributes them.
//
//  channel | ports                         | handshake
//  in      | start, busy, in_word          | taken when start & !busy
//  out     | out_valid, out_word           | one-cycle strobe, no back-pressure
//  cfg     | cfg_we, cfg_index, cfg_data   | written when cfg_we
//
// Loading takes one box per cycle while busy is low. After the box marked last,
// a decide state, then for distribute modes a bit-serial gap divider, then a
// rotation of the chain computing new coordinates (skipped on error or with
// fewer than two boxes), then one result per cycle. With an invalid size in a
// distribute mode the chain rotates and each result waits for its box to reach
// the head cell. busy stays high from the last box to the final result. Reset is
// synchronous; results cannot be stalled.
`default_nettype none
module box_align_distribute (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire bad_pkg::in_word_t in_word,
  output logic                   out_valid,
  output bad_pkg::out_word_t     out_word,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [30:0]       cfg_data
);
  import bad_pkg::*;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r;
  logic [30:0]              fb_w_r, fb_h_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [32:0]       min_x_r, min_y_r, max_x_r, max_y_r;
  logic                     err_r;
  logic signed [ACC_W-1:0]  tot_r, cursor_r, gap_r;
  status_t                  status_r;
  logic [ACC_W-1:0]         dvd_r, quo_r;
  logic [CNT_W-1:0]         rem_r;
  logic                     neg_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [IDX_W-1:0]         ccnt_r;
  logic [CNT_W-1:0]         ecnt_r;
  logic                     out_valid_r;
  out_word_t                out_word_r;

  cell_ctl_t                ctl;
  entry_t                   new_entry, tail_in, c0, calc_entry;
  entry_t                   cell_q [MAX_NODES];
  logic                     cell_bf [MAX_NODES];

  logic                     accept, store, is_dist, horiz, last_emit, sat;
  logic                     pick, emit_now;
  logic signed [31:0]       w_eff, h_eff;
  logic signed [32:0]       end_x, end_y;
  logic signed [ACC_W-1:0]  ext, num, vx, vy, mnx, mxx, mny, mxy;
  logic [CNT_W-1:0]         divisor;
  logic [CNT_W:0]           rem_sh;
  logic                     ge;
  logic [ACC_W-1:0]         q_fin;

  assign is_dist = (mode_r == MODE_DIST_H) || (mode_r == MODE_DIST_V);
  assign horiz   = (mode_r != MODE_DIST_V);
  assign accept  = start && !busy;
  assign store   = accept && (count_r < CNT_W'(MAX_NODES));

  // load path
  always_comb begin
    w_eff = in_word.width;
    h_eff = in_word.height;
    if (!in_word.size_is_override && in_word.width <= 0) w_eff = $signed({1'b0, fb_w_r});
    if (!in_word.size_is_override && in_word.height <= 0) h_eff = $signed({1'b0, fb_h_r});
    end_x = 33'(in_word.pos_x) + 33'(w_eff);
    end_y = 33'(in_word.pos_y) + 33'(h_eff);
    new_entry = '{valid: 1'b1, seq: count_r[IDX_W-1:0], id: in_word.box_id,
                  x: in_word.pos_x, y: in_word.pos_y,
                  w: w_eff, h: h_eff, nx: in_word.pos_x, ny: in_word.pos_y};
  end

  // chain
  for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_b;
    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_b = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = cell_bf[i-1];
    end
    if (i == MAX_NODES - 1) begin : g_tail
      assign right_e = tail_in;
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end
    bad_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_before (left_b),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .goes_first  (cell_bf[i])
    );
  end

  assign c0 = cell_q[0];

  // coordinate calculation on the head cell
  always_comb begin
    mnx = ACC_W'(min_x_r);
    mxx = ACC_W'(max_x_r);
    mny = ACC_W'(min_y_r);
    mxy = ACC_W'(max_y_r);
    vx  = ACC_W'(c0.x);
    vy  = ACC_W'(c0.y);
    unique case (mode_r)
      MODE_LEFT:    vx = mnx;
      MODE_HCENTER: vx = (mnx + mxx - ACC_W'(c0.w)) >>> 1;
      MODE_RIGHT:   vx = mxx - ACC_W'(c0.w);
      MODE_TOP:     vy = mny;
      MODE_VCENTER: vy = (mny + mxy - ACC_W'(c0.h)) >>> 1;
      MODE_BOTTOM:  vy = mxy - ACC_W'(c0.h);
      MODE_DIST_H:  vx = cursor_r;
      MODE_DIST_V:  vy = cursor_r;
      default:      vx = ACC_W'(c0.x);
    endcase
    sat = c0.valid && (out_of_range(vx) || out_of_range(vy));
    calc_entry    = c0;
    calc_entry.nx = clamp32(vx);
    calc_entry.ny = clamp32(vy);
    ext = horiz ? ACC_W'(max_x_r) - ACC_W'(min_x_r) : ACC_W'(max_y_r) - ACC_W'(min_y_r);
    num = ext - tot_r;
  end

  // gap divider step
  always_comb begin
    divisor = count_r - CNT_W'(1);
    rem_sh  = {rem_r, dvd_r[ACC_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    q_fin   = {quo_r[ACC_W-2:0], ge};
  end

  // load-order pick from the rotating chain
  assign pick      = (state_r == S_PICK) && c0.valid && (c0.seq == ecnt_r[IDX_W-1:0]);
  assign emit_now  = (state_r == S_EMIT) || pick;
  assign last_emit = emit_now && (ecnt_r == count_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (accept && in_word.last_box) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (count_r < CNT_W'(2)) state_nxt = S_EMIT;
        else if (err_r) state_nxt = is_dist ? S_PICK : S_EMIT;
        else if (is_dist) state_nxt = S_DIV;
        else state_nxt = S_CALC;
      end
      S_DIV:    if (dcnt_r == DCNT_W'(ACC_W - 1)) state_nxt = S_CALC;
      S_CALC:   if (ccnt_r == IDX_W'(MAX_NODES - 1)) state_nxt = S_EMIT;
      S_EMIT:   if (last_emit) state_nxt = S_LOAD;
      S_PICK:   if (last_emit) state_nxt = S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy       = (state_r != S_LOAD);
    ctl.by_y   = (mode_r == MODE_DIST_V);
    ctl.sorted = is_dist;
    ctl.op     = CELL_HOLD;
    tail_in    = '0;
    unique case (state_r)
      S_LOAD:   if (store) ctl.op = CELL_INSERT;
      S_CALC: begin
        ctl.op  = CELL_ROTATE;
        tail_in = calc_entry;
      end
      S_PICK: begin
        ctl.op = CELL_ROTATE;
        if (!pick) tail_in = c0;
      end
      S_EMIT:   ctl.op = CELL_SHIFT;
      S_DECIDE,
      S_DIV:    ctl.op = CELL_HOLD;
      default:  ctl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mode_r      <= MODE_LEFT;
      fb_w_r      <= 31'd65536;
      fb_h_r      <= 31'd65536;
      count_r     <= '0;
      min_x_r     <= 33'sh0FFFFFFFF;
      min_y_r     <= 33'sh0FFFFFFFF;
      max_x_r     <= 33'sh100000000;
      max_y_r     <= 33'sh100000000;
      err_r       <= 1'b0;
      tot_r       <= '0;
      status_r    <= ST_OK;
      dcnt_r      <= '0;
      ccnt_r      <= '0;
      ecnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE: mode_r <= mode_t'(cfg_data[2:0]);
          REG_FB_W: fb_w_r <= cfg_data;
          REG_FB_H: fb_h_r <= cfg_data;
          default:  mode_r <= mode_r;
        endcase
      end
      unique case (state_r)
        S_LOAD: begin
          if (store) begin
            count_r <= count_r + CNT_W'(1);
            if (w_eff <= 0 || h_eff <= 0) err_r <= 1'b1;
            if (33'(in_word.pos_x) < min_x_r) min_x_r <= 33'(in_word.pos_x);
            if (33'(in_word.pos_y) < min_y_r) min_y_r <= 33'(in_word.pos_y);
            if (end_x > max_x_r) max_x_r <= end_x;
            if (end_y > max_y_r) max_y_r <= end_y;
            tot_r <= tot_r + ACC_W'(horiz ? w_eff : h_eff);
          end
        end
        S_DECIDE: begin
          if (count_r < CNT_W'(2)) status_r <= ST_FEW;
          else if (err_r) status_r <= ST_SIZE;
          else status_r <= ST_OK;
          neg_r    <= num < 0;
          dvd_r    <= (num < 0) ? ACC_W'(-num) : ACC_W'(num);
          quo_r    <= '0;
          rem_r    <= '0;
          dcnt_r   <= '0;
          ccnt_r   <= '0;
          ecnt_r   <= '0;
          gap_r    <= '0;
          cursor_r <= horiz ? ACC_W'(min_x_r) : ACC_W'(min_y_r);
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, divisor}) : CNT_W'(rem_sh);
          dvd_r  <= {dvd_r[ACC_W-2:0], 1'b0};
          quo_r  <= q_fin;
          if (dcnt_r == DCNT_W'(ACC_W - 1)) gap_r <= neg_r ? -$signed(q_fin) : $signed(q_fin);
        end
        S_CALC: begin
          ccnt_r <= ccnt_r + IDX_W'(1);
          if (sat) status_r <= ST_SAT;
          if (c0.valid)
            cursor_r <= cursor_r + ACC_W'(horiz ? c0.w : c0.h) + gap_r;
        end
        S_EMIT,
        S_PICK: begin
          if (emit_now) begin
            ecnt_r      <= ecnt_r + CNT_W'(1);
            out_valid_r <= 1'b1;
            if (last_emit) begin
              count_r <= '0;
              min_x_r <= 33'sh0FFFFFFFF;
              min_y_r <= 33'sh0FFFFFFFF;
              max_x_r <= 33'sh100000000;
              max_y_r <= 33'sh100000000;
              err_r   <= 1'b0;
              tot_r   <= '0;
            end
          end
        end
        default: status_r <= status_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_word_r <= '{out_id: c0.id, new_x: c0.nx, new_y: c0.ny,
                      status: status_r, last_result: last_emit};
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES)) else $error("box count overflow");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> c0.valid) else $error("emitting an empty cell");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.last_result |=> !out_valid_r) else $error("word after last");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT || $past(state_r) == S_PICK))
    else $error("stray result");
endmodule
`default_nettype wire

@@ sim/box_align_distribute_tb.sv @@
// Testbench for box_align_distribute: directed table and random box sets checked by a predictor.
`default_nettype none
module box_align_distribute_tb;
  import bad_pkg::*;

  localparam int SETTLE = ACC_W + 3 * MAX_NODES + 16;

  typedef struct {
    mode_t       mode;
    logic [30:0] fbw;
    logic [30:0] fbh;
    in_word_t    w;
    bit          typed;
    out_word_t   exp;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  box_align_distribute DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  mode_t       cur_mode = MODE_LEFT;
  logic [30:0] cur_fbw = 31'd65536;
  logic [30:0] cur_fbh = 31'd65536;
  logic [31:0] set_ids [MAX_NODES];
  longint      set_x [MAX_NODES];
  longint      set_y [MAX_NODES];
  longint      set_w [MAX_NODES];
  longint      set_h [MAX_NODES];
  int          set_cnt = 0;
  longint      min_x, min_y, max_x, max_y;
  bit          size_bad = 0;

  out_word_t placed_q[$];
  int        errors = 0;

  function automatic void clear_bounds();
    set_cnt = 0;
    size_bad = 0;
    min_x = 64'sd4294967295;
    min_y = 64'sd4294967295;
    max_x = -64'sd4294967296;
    max_y = -64'sd4294967296;
  endfunction

  function automatic longint clip32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic bit ahead_of(input int a, input int b, input bit horiz);
    longint ka, kb;
    ka = horiz ? set_x[a] : set_y[a];
    kb = horiz ? set_x[b] : set_y[b];
    if (ka != kb) return ka < kb;
    if (set_ids[a] != set_ids[b]) return set_ids[a] < set_ids[b];
    return a < b;
  endfunction

  // absorbs one box; on the last box queues the placements of the whole set
  function automatic void place_boxes(input in_word_t w, output int n_out);
    longint    bw, bh, nx[MAX_NODES], ny[MAX_NODES], total, gap, cur;
    int        ord[MAX_NODES];
    int        n, i, j, k, c;
    bit        sat, horiz;
    status_t   st;
    out_word_t r;
    n_out = 0;
    if (set_cnt < MAX_NODES) begin
      bw = longint'(w.width);
      bh = longint'(w.height);
      if (!w.size_is_override) begin
        if (bw <= 0) bw = longint'(cur_fbw);
        if (bh <= 0) bh = longint'(cur_fbh);
      end
      if (bw <= 0 || bh <= 0) size_bad = 1;
      set_ids[set_cnt] = w.box_id;
      set_x[set_cnt] = longint'(w.pos_x);
      set_y[set_cnt] = longint'(w.pos_y);
      set_w[set_cnt] = bw;
      set_h[set_cnt] = bh;
      if (set_x[set_cnt] < min_x) min_x = set_x[set_cnt];
      if (set_y[set_cnt] < min_y) min_y = set_y[set_cnt];
      if (set_x[set_cnt] + bw > max_x) max_x = set_x[set_cnt] + bw;
      if (set_y[set_cnt] + bh > max_y) max_y = set_y[set_cnt] + bh;
      set_cnt++;
    end
    if (!w.last_box) return;
    n = set_cnt;
    sat = 0;
    for (i = 0; i < n; i++) begin
      ord[i] = i;
      nx[i] = set_x[i];
      ny[i] = set_y[i];
    end
    if (n < 2) st = ST_FEW;
    else if (size_bad) st = ST_SIZE;
    else begin
      st = ST_OK;
      if (cur_mode == MODE_DIST_H || cur_mode == MODE_DIST_V) begin
        horiz = (cur_mode == MODE_DIST_H);
        for (i = 1; i < n; i++) begin
          c = ord[i];
          j = i;
          while (j > 0 && ahead_of(c, ord[j-1], horiz)) begin
            ord[j] = ord[j-1];
            j--;
          end
          ord[j] = c;
        end
        total = 0;
        for (i = 0; i < n; i++) total += horiz ? set_w[i] : set_h[i];
        gap = ((horiz ? max_x - min_x : max_y - min_y) - total) / longint'(n - 1);
        cur = horiz ? min_x : min_y;
        for (i = 0; i < n; i++) begin
          k = ord[i];
          if (horiz) begin
            nx[k] = clip32(cur, sat);
            cur += set_w[k] + gap;
          end else begin
            ny[k] = clip32(cur, sat);
            cur += set_h[k] + gap;
          end
        end
      end else begin
        for (i = 0; i < n; i++) begin
          case (cur_mode)
            MODE_LEFT:    nx[i] = min_x;
            MODE_HCENTER: nx[i] = (min_x + max_x - set_w[i]) >>> 1;
            MODE_RIGHT:   nx[i] = max_x - set_w[i];
            MODE_TOP:     ny[i] = min_y;
            MODE_VCENTER: ny[i] = (min_y + max_y - set_h[i]) >>> 1;
            default:      ny[i] = max_y - set_h[i];
          endcase
          nx[i] = clip32(nx[i], sat);
          ny[i] = clip32(ny[i], sat);
        end
      end
      if (sat) st = ST_SAT;
    end
    for (i = 0; i < n; i++) begin
      k = ord[i];
      r.out_id = set_ids[k];
      r.new_x = nx[k][31:0];
      r.new_y = ny[k][31:0];
      r.status = st;
      r.last_result = (i == n - 1);
      placed_q = {placed_q, r};
    end
    n_out = n;
    clear_bounds();
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      if (placed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word id=%h", out_word.out_id);
      end else begin
        e = placed_q.pop_front();
        if (out_word.out_id !== e.out_id || out_word.new_x !== e.new_x ||
            out_word.new_y !== e.new_y || out_word.status !== e.status ||
            out_word.last_result !== e.last_result) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp id=%h x=%h y=%h st=%0d l=%b got id=%h x=%h y=%h st=%0d l=%b",
                     e.out_id, e.new_x, e.new_y, e.status, e.last_result,
                     out_word.out_id, out_word.new_x, out_word.new_y,
                     out_word.status, out_word.last_result);
        end
      end
    end
  end

  task automatic wait_idle();
    while (placed_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(input mode_t m, input logic [30:0] fw, input logic [30:0] fh);
    wait_idle();
    write_reg(REG_MODE, 31'(m));
    write_reg(REG_FB_W, fw);
    write_reg(REG_FB_H, fh);
    cur_mode = m;
    cur_fbw = fw;
    cur_fbh = fh;
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_word(input in_word_t w, input int gap);
    int n;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (busy) begin
      start = 1'b0;
      while (busy) @(negedge clk);
    end
    start = 1'b1;
    in_word = w;
    place_boxes(w, n);
    @(negedge clk);
  endtask

  function automatic in_word_t mk(input logic [31:0] id, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] w,
                                  input logic [31:0] h, input bit ovr, input bit last);
    in_word_t r;
    r.box_id = id; r.pos_x = x; r.pos_y = y; r.width = w; r.height = h;
    r.size_is_override = ovr; r.last_box = last;
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_size();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h80000000 | $urandom();
      2: return $urandom();
      3: return 32'h7FFFFFFF;
      default: return $urandom_range(1, 300000);
    endcase
  endfunction

  function automatic logic [30:0] rnd_fb();
    case ($urandom_range(0, 5))
      0: return 31'd1;
      1: return 31'h7FFFFFFF;
      2: return 31'd0;
      3: return 31'($urandom());
      default: return 31'($urandom_range(1, 200000));
    endcase
  endfunction

  dir_row_t dir_rows[$];

  function automatic void add_row(input mode_t m, input logic [30:0] fw, input logic [30:0] fh,
                                  input in_word_t w);
    dir_row_t r;
    r.mode = m; r.fbw = fw; r.fbh = fh; r.w = w; r.typed = 0; r.exp = '0;
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    dir_row_t r;
    in_word_t w;
    out_word_t sent;
    bit fresh, ovr_on, dup_ids, flat;
    int items, nbox, gap, nr, burst;
    mode_t m;

    clear_bounds();
    // lone box: position unchanged, too-few status
    add_row(MODE_LEFT, 31'd65536, 31'd65536, mk(32'd5, 32'd100, -32'sd7, 0, 0, 0, 1));
    dir_rows[$].typed = 1;
    dir_rows[$].exp = '{32'd5, 32'd100, -32'sd7, ST_FEW, 1'b1};
    // lone box with bad override: too-few wins over invalid size
    add_row(MODE_LEFT, 31'd65536, 31'd65536,
            mk(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 1, 1));
    dir_rows[$].typed = 1;
    dir_rows[$].exp = '{32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, ST_FEW, 1'b1};
    add_row(MODE_LEFT, 31'd65536, 31'd65536, mk(1, 10, 20, 0, 5, 1, 0));
    add_row(MODE_LEFT, 31'd65536, 31'd65536, mk(2, 30, 40, 7, 8, 0, 1));
    add_row(MODE_HCENTER, 31'd65536, 31'd65536, mk(3, -3, 0, -5, -9, 0, 0));
    add_row(MODE_HCENTER, 31'd65536, 31'd65536, mk(4, -1, 6, 2, 3, 1, 1));
    add_row(MODE_RIGHT, 31'h7FFFFFFF, 31'd1, mk(5, 32'h7FFF0000, 0, 0, 0, 0, 0));
    add_row(MODE_RIGHT, 31'h7FFFFFFF, 31'd1, mk(6, 32'h80000000, 9, 3, 0, 0, 1));
    add_row(MODE_TOP, 31'd1, 31'h7FFFFFFF, mk(7, 5, -100, 4, 0, 0, 0));
    add_row(MODE_TOP, 31'd1, 31'h7FFFFFFF, mk(8, 6, 300, 0, 4, 0, 1));
    add_row(MODE_VCENTER, 31'd65536, 31'd65536, mk(9, 0, 32'h80000000, 1, 1, 1, 0));
    add_row(MODE_VCENTER, 31'd65536, 31'd65536,
            mk(10, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1, 1));
    add_row(MODE_BOTTOM, 31'd65536, 31'd65536, mk(11, 0, 32'h80000000, 1, 1, 1, 0));
    add_row(MODE_BOTTOM, 31'd65536, 31'd65536,
            mk(12, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1, 1));
    add_row(MODE_DIST_H, 31'd65536, 31'd65536, mk(3, 0, 0, 10, 1, 1, 0));
    add_row(MODE_DIST_H, 31'd65536, 31'd65536, mk(1, 0, 0, 20, 1, 1, 0));
    add_row(MODE_DIST_H, 31'd65536, 31'd65536, mk(1, 0, 5, 30, 1, 1, 0));
    add_row(MODE_DIST_H, 31'd65536, 31'd65536, mk(0, 500, 5, 7, 1, 1, 1));
    add_row(MODE_DIST_V, 31'd65536, 31'd65536, mk(20, 0, 50, 1, 100, 1, 0));
    add_row(MODE_DIST_V, 31'd65536, 31'd65536, mk(21, 0, -20, 1, 90, 1, 0));
    add_row(MODE_DIST_V, 31'd65536, 31'd65536, mk(22, 0, 10, 1, 0, 0, 1));
    // fallback of zero makes the size invalid
    add_row(MODE_RIGHT, 31'd0, 31'd0, mk(23, 1, 2, 0, 3, 0, 0));
    add_row(MODE_RIGHT, 31'd0, 31'd0, mk(24, 4, 5, 6, 7, 0, 1));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    fresh = 1;
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (fresh && (r.mode != cur_mode || r.fbw != cur_fbw || r.fbh != cur_fbh)) begin
        start = 1'b0;
        set_regs(r.mode, r.fbw, r.fbh);
      end
      if (r.typed) begin
        start = 1'b0;
        wait_idle();
        send_word(r.w, 0);
        placed_q[$] = r.exp;
      end else begin
        send_word(r.w, $urandom_range(0, 3));
      end
      fresh = r.w.last_box;
    end

    items = 0;
    while (items < 300) begin
      if ($urandom_range(0, 2) == 0) begin
        start = 1'b0;
        m = mode_t'($urandom_range(0, 7));
        set_regs(m, rnd_fb(), rnd_fb());
      end else if ($urandom_range(0, 15) == 0) begin
        start = 1'b0;
        wait_idle();
      end
      case ($urandom_range(0, 19))
        0:       nbox = 1;
        1:       nbox = $urandom_range(MAX_NODES, MAX_NODES + 2);
        default: nbox = $urandom_range(2, 8);
      endcase
      ovr_on = ($urandom_range(0, 3) == 0);
      dup_ids = ($urandom_range(0, 2) == 0);
      flat = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(0, 2) == 0;
      for (int b = 0; b < nbox; b++) begin
        w.box_id = dup_ids ? $urandom_range(0, 3) : $urandom();
        w.pos_x = flat ? 32'($urandom_range(0, 2)) : rnd_coord();
        w.pos_y = flat ? 32'($urandom_range(0, 2)) : rnd_coord();
        w.width = rnd_size();
        w.height = rnd_size();
        w.size_is_override = ovr_on ? ($urandom_range(0, 7) != 0) : 1'b0;
        if (ovr_on && w.size_is_override && $urandom_range(0, 5) != 0) begin
          if (w.width[31] || w.width == 0) w.width = $urandom_range(1, 1000);
          if (w.height[31] || w.height == 0) w.height = $urandom_range(1, 1000);
        end
        w.last_box = (b == nbox - 1);
        gap = burst ? 0 : $urandom_range(0, 13);
        send_word(w, gap);
        items++;
      end
    end
    start = 1'b0;

    while (placed_q.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && placed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

@@ box_align_distribute.f @@
hw/rtl/bad_pkg.sv
hw/rtl/bad_cell.sv
hw/rtl/box_align_distribute.sv
sim/box_align_distribute_tb.sv
